FILE: sv/bpsd_pkg.sv
// Shared types and constants for the BMP pixel stream decoder.
package bpsd_pkg;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned HEADER_BYTES = 54;

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned ROWB_W = $clog2(4 * MAX_DIM + 1);
  localparam int unsigned PROD_W = DIM_W + ROWB_W;
  localparam int unsigned NEED_W = ((PROD_W > 32) ? PROD_W : 32) + 1;
  localparam int unsigned HDR_W  = $clog2(HEADER_BYTES);

  localparam logic [HDR_W-1:0] OFF_POS  = HDR_W'(10);
  localparam logic [HDR_W-1:0] WID_POS  = HDR_W'(18);
  localparam logic [HDR_W-1:0] HGT_POS  = HDR_W'(22);
  localparam logic [HDR_W-1:0] DEP_POS  = HDR_W'(28);
  localparam logic [HDR_W-1:0] LAST_HDR = HDR_W'(HEADER_BYTES - 1);

  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  localparam int unsigned OUT_DATA_W = 64;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_HDR_SHORT  = 3'd1,
    ST_BAD_DEPTH  = 3'd2,
    ST_DATA_SHORT = 3'd3,
    ST_TOO_LARGE  = 3'd4,
    ST_BAD_OFFSET = 3'd5
  } status_e;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_CHK_A  = 8'b0000_0010,
    PH_CHK_B  = 8'b0000_0100,
    PH_CHK_C  = 8'b0000_1000,
    PH_SKIP   = 8'b0001_0000,
    PH_PIXEL  = 8'b0010_0000,
    PH_PAD    = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    status_e          status;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             neg;
    logic             bpp4;
  } geom_t;

endpackage

FILE: sv/bmp_pixel_stream_decoder.sv
// Top level of the BMP pixel stream decoder.
//   channel  | direction | carries
//   s_axis   | in        | one file byte per item, tdata[7:0]
//   m_axis   | out       | one pixel or error per item, status in tuser, tlast on final pixel
//   cfg      | in        | file length in bytes, written with cfg_wen_i
// One file byte is taken per cycle while the queue is not full; after the last
// header byte the input stalls while the header checks run (abs height and row
// size, then the height-by-row-size multiply, then the length compare).
// Reset clears the parse state and the file length register.
// A two-entry queue and the output register let the input keep moving
// while a result waits on m_axis_tready, until the queue fills.
module bmp_pixel_stream_decoder import bpsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wen_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] file_byte
  input  logic [7:0]            s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [34:32] channel_count,
  // [46:35] column, [58:47] image_row, [63:59] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic  q_full;
  logic  push;
  item_t push_item;
  geom_t geom;
  logic  pop;
  logic  q_valid;
  item_t q_head;

  bpsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item),
    .geom_o      (geom)
  );

  bpsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  bpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .geom_i      (geom),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: sv/bpsd_front.sv
// Front end: header capture, checks, skip and padding, pixel byte assembly.
module bpsd_front import bpsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       push_item_o,
  output geom_t       geom_o
);

  logic [31:0]       file_length_q;
  phase_e            phase_q, phase_d;
  logic [31:0]       byte_pos_q, byte_pos_d;
  logic [31:0]       start_q, start_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       height_q, height_d;
  logic [15:0]       depth_q, depth_d;
  logic [DIM_W-1:0]  col_q, col_d;
  logic [DIM_W-1:0]  row_q, row_d;
  logic [1:0]        kpix_q, kpix_d;
  logic [1:0]        pad_q, pad_d;
  logic [23:0]       held_q, held_d;
  logic              bad_depth_q, bad_dim_q, bad_off_q;
  logic [DIM_W-1:0]  habs_q;
  logic [ROWB_W-1:0] rowb_q;
  logic [PROD_W-1:0] prod_q;

  logic              accept;
  logic              bpp4;
  logic [HDR_W-1:0]  pos;
  logic [HDR_W-1:0]  sub;
  logic [31:0]       habs32;
  logic [ROWB_W-1:0] raw_b;
  logic [NEED_W-1:0] need;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  row_inc;

  assign bpp4   = (depth_q == DEPTH_32);
  assign pos    = byte_pos_q[HDR_W-1:0];
  assign sub    = pos - OFF_POS;
  assign habs32 = height_q[31] ? (~height_q + 32'd1) : height_q;
  assign raw_b  = bpp4 ? (ROWB_W'(width_q[DIM_W-1:0]) << 2)
                       : (ROWB_W'(width_q[DIM_W-1:0]) + (ROWB_W'(width_q[DIM_W-1:0]) << 1));
  assign need   = NEED_W'(start_q) + NEED_W'(prod_q);
  assign col_inc = col_q + DIM_W'(1);
  assign row_inc = row_q + DIM_W'(1);

  assign in_ready_o = !q_full_i && (phase_q == PH_HEADER || phase_q == PH_SKIP ||
                                    phase_q == PH_PIXEL || phase_q == PH_PAD ||
                                    phase_q == PH_DONE);
  assign accept = in_valid_i && in_ready_o;

  assign geom_o.width  = width_q[DIM_W-1:0];
  assign geom_o.height = habs_q;
  assign geom_o.neg    = height_q[31];
  assign geom_o.bpp4   = bpp4;

  always_comb begin
    phase_d     = phase_q;
    byte_pos_d  = byte_pos_q;
    start_d     = start_q;
    width_d     = width_q;
    height_d    = height_q;
    depth_d     = depth_q;
    col_d       = col_q;
    row_d       = row_q;
    kpix_d      = kpix_q;
    pad_d       = pad_q;
    held_d      = held_q;
    push_o      = 1'b0;
    push_item_o = '0;
    case (phase_q)
      PH_HEADER: begin
        if (accept) begin
          byte_pos_d = byte_pos_q + 32'd1;
          if (pos == '0 && file_length_q < 32'(HEADER_BYTES)) begin
            push_o             = 1'b1;
            push_item_o.status = ST_HDR_SHORT;
            phase_d            = PH_DONE;
          end else if (pos == LAST_HDR) begin
            phase_d = PH_CHK_A;
          end
        end
      end
      PH_CHK_A: phase_d = PH_CHK_B;
      PH_CHK_B: phase_d = PH_CHK_C;
      PH_CHK_C: begin
        if (!q_full_i) begin
          if (bad_depth_q || bad_dim_q || bad_off_q ||
              need > NEED_W'(file_length_q)) begin
            push_o  = 1'b1;
            phase_d = PH_DONE;
            if (bad_depth_q) begin
              push_item_o.status = ST_BAD_DEPTH;
            end else if (bad_dim_q) begin
              push_item_o.status = ST_TOO_LARGE;
            end else if (bad_off_q) begin
              push_item_o.status = ST_BAD_OFFSET;
            end else begin
              push_item_o.status = ST_DATA_SHORT;
            end
          end else if (width_q == '0 || habs_q == '0) begin
            phase_d = PH_DONE;
          end else if (start_q == 32'(HEADER_BYTES)) begin
            phase_d = PH_PIXEL;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (accept) begin
          byte_pos_d = byte_pos_q + 32'd1;
          if (byte_pos_d == start_q) begin
            phase_d = PH_PIXEL;
          end
        end
      end
      PH_PIXEL: begin
        if (accept) begin
          if ((bpp4 && kpix_q != 2'd3) || (!bpp4 && kpix_q != 2'd2)) begin
            held_d[{kpix_q, 3'b000} +: 8] = in_byte_i;
            kpix_d = kpix_q + 2'd1;
          end else begin
            push_o             = 1'b1;
            push_item_o.status = ST_PIXEL;
            push_item_o.blue   = held_q[7:0];
            push_item_o.green  = held_q[15:8];
            push_item_o.red    = bpp4 ? held_q[23:16] : in_byte_i;
            push_item_o.alpha  = bpp4 ? in_byte_i : 8'd0;
            push_item_o.col    = col_q;
            push_item_o.row    = row_q;
            kpix_d = 2'd0;
            held_d = '0;
            col_d  = col_inc;
            if (col_inc >= width_q[DIM_W-1:0]) begin
              col_d = '0;
              row_d = row_inc;
              if (row_inc >= habs_q) begin
                phase_d = PH_DONE;
              end else if (!bpp4 && width_q[1:0] != 2'd0) begin
                pad_d   = width_q[1:0];
                phase_d = PH_PAD;
              end
            end
          end
        end
      end
      PH_PAD: begin
        if (accept) begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) begin
            phase_d = PH_PIXEL;
          end
        end
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
      phase_q       <= PH_HEADER;
      byte_pos_q    <= '0;
      start_q       <= '0;
      width_q       <= '0;
      height_q      <= '0;
      depth_q       <= '0;
      col_q         <= '0;
      row_q         <= '0;
      kpix_q        <= '0;
      pad_q         <= '0;
      held_q        <= '0;
    end else begin
      if (cfg_wen_i) begin
        file_length_q <= cfg_wdata_i;
      end
      phase_q    <= phase_d;
      byte_pos_q <= byte_pos_d;
      col_q      <= col_d;
      row_q      <= row_d;
      kpix_q     <= kpix_d;
      pad_q      <= pad_d;
      held_q     <= held_d;
      if (phase_q == PH_HEADER && accept) begin
        if (pos >= OFF_POS && pos < OFF_POS + HDR_W'(4)) begin
          start_q[{sub[1:0], 3'b000} +: 8] <= in_byte_i;
        end
        if (pos >= WID_POS && pos < WID_POS + HDR_W'(4)) begin
          width_q[{pos[1:0] - WID_POS[1:0], 3'b000} +: 8] <= in_byte_i;
        end
        if (pos >= HGT_POS && pos < HGT_POS + HDR_W'(4)) begin
          height_q[{pos[1:0] - HGT_POS[1:0], 3'b000} +: 8] <= in_byte_i;
        end
        if (pos >= DEP_POS && pos < DEP_POS + HDR_W'(2)) begin
          depth_q[{pos[0] ^ DEP_POS[0], 3'b000} +: 8] <= in_byte_i;
        end
      end else begin
        start_q  <= start_d;
        width_q  <= width_d;
        height_q <= height_d;
        depth_q  <= depth_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_CHK_A) begin
      bad_depth_q <= (depth_q != DEPTH_24) && (depth_q != DEPTH_32);
      bad_dim_q   <= (width_q > 32'(MAX_DIM)) || (habs32 > 32'(MAX_DIM));
      bad_off_q   <= start_q < 32'(HEADER_BYTES);
      habs_q      <= habs32[DIM_W-1:0];
      rowb_q      <= (raw_b + ROWB_W'(3)) & ~ROWB_W'(3);
    end
    if (phase_q == PH_CHK_B) begin
      prod_q <= PROD_W'(habs_q) * PROD_W'(rowb_q);
    end
  end

endmodule

FILE: sv/bpsd_queue.sv
// Two-entry queue between the front end and the output stage.
module bpsd_queue import bpsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: sv/bpsd_back.sv
// Output stage: row flip, last flag, field packing and output register.
module bpsd_back import bpsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  item_t                 q_head_i,
  output logic                  pop_o,
  input  geom_t                 geom_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [2:0]            out_user_o,
  output logic                  out_last_o
);

  logic                  valid_q;
  logic [OUT_DATA_W-1:0] data_q;
  logic [2:0]            user_q;
  logic                  last_q;
  logic                  is_pix;
  logic [DIM_W-1:0]      row_flip;
  logic [CNT_W-1:0]      row_out;
  logic [2:0]            chan;
  logic                  last;
  logic [OUT_DATA_W-1:0] data_d;

  assign pop_o    = q_valid_i && (!valid_q || out_ready_i);
  assign is_pix   = (q_head_i.status == ST_PIXEL);
  assign row_flip = geom_i.height - DIM_W'(1) - q_head_i.row;
  assign row_out  = geom_i.neg ? q_head_i.row[CNT_W-1:0] : row_flip[CNT_W-1:0];
  assign chan     = geom_i.bpp4 ? 3'd4 : 3'd3;
  assign last     = is_pix && (q_head_i.row + DIM_W'(1) == geom_i.height) &&
                    (q_head_i.col + DIM_W'(1) == geom_i.width);

  always_comb begin
    data_d = '0;
    if (is_pix) begin
      data_d[7:0]   = q_head_i.red;
      data_d[15:8]  = q_head_i.green;
      data_d[23:16] = q_head_i.blue;
      data_d[31:24] = q_head_i.alpha;
      data_d[34:32] = chan;
      data_d[46:35] = q_head_i.col[CNT_W-1:0];
      data_d[58:47] = row_out;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= q_head_i.status;
      last_q <= last;
    end
  end

endmodule
